// ===== src/idks_pkg.sv =====
// shared types, constants and word table for the identifier and keyword scanner
`timescale 1ns / 1ps
`default_nettype none
package idks_pkg;

  localparam int MAX_TEXT_DEF = 32;
  localparam int POS_BITS_DEF = 32;
  localparam int WORD_COUNT = 27;
  localparam int WORD_MAX = 9;
  localparam logic [15:0] SPACE = 16'h0020;

  typedef enum logic [1:0] {
    KIND_PASS    = 2'd0,
    KIND_KEYWORD = 2'd1,
    KIND_BOOL    = 2'd2,
    KIND_TEXT    = 2'd3
  } kind_t;

  typedef struct packed {
    logic       hit;
    logic       is_bool;
    logic [3:0] code;
  } match_t;

  localparam logic [3:0] WORD_LEN [WORD_COUNT] = '{
    4'd6, 4'd2, 4'd7, 4'd4, 4'd4, 4'd4, 4'd5, 4'd9, 4'd4, 4'd3, 4'd5,
    4'd2, 4'd2, 4'd1, 4'd3, 4'd2, 4'd2, 4'd2, 4'd1, 4'd4, 4'd2, 4'd2, 4'd2,
    4'd4, 4'd5, 4'd1, 4'd1
  };

  localparam logic WORD_BOOL [WORD_COUNT] = '{
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b1, 1'b1, 1'b1, 1'b1
  };

  localparam logic [3:0] WORD_CODE [WORD_COUNT] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10,
    4'd0, 4'd1, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10,
    4'd1, 4'd0, 4'd1, 4'd0
  };

  localparam logic [15:0] WORD_UNIT [WORD_COUNT][WORD_MAX] = '{
    '{16'h0069, 16'h006D, 16'h0070, 16'h006F, 16'h0072, 16'h0074, 16'h0, 16'h0, 16'h0},
    '{16'h0069, 16'h0066, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
    '{16'h0065, 16'h006C, 16'h0073, 16'h0065, 16'h0020, 16'h0069, 16'h0066, 16'h0, 16'h0},
    '{16'h0065, 16'h006C, 16'h0073, 16'h0065, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
    '{16'h006C, 16'h006F, 16'h006F, 16'h0070, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
    '{16'h0066, 16'h0075, 16'h006E, 16'h0063, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
    '{16'h0063, 16'h006C, 16'h0061, 16'h0073, 16'h0073, 16'h0, 16'h0, 16'h0, 16'h0},
    '{16'h006E, 16'h0061, 16'h006D, 16'h0065, 16'h0073, 16'h0070, 16'h0061, 16'h0063,
      16'h0065},
    '{16'h0065, 16'h006E, 16'h0075, 16'h006D, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
    '{16'h0074, 16'h0072, 16'h0079, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
    '{16'h0063, 16'h0061, 16'h0074, 16'h0063, 16'h0068, 16'h0, 16'h0, 16'h0, 16'h0},
    '{16'h5BFC, 16'h5165, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
    '{16'h5982, 16'h679C, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
    '{16'h82E5, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
    '{16'h53C8, 16'h5982, 16'h679C, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
    '{16'h5426, 16'h5219, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
    '{16'h5FAA, 16'h73AF, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
    '{16'h51FD, 16'h6570, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
    '{16'h7C7B, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
    '{16'h547D, 16'h540D, 16'h7A7A, 16'h95F4, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
    '{16'h679A, 16'h4E3E, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
    '{16'h5C1D, 16'h8BD5, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
    '{16'h6355, 16'h83B7, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
    '{16'h0074, 16'h0072, 16'h0075, 16'h0065, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
    '{16'h0066, 16'h0061, 16'h006C, 16'h0073, 16'h0065, 16'h0, 16'h0, 16'h0, 16'h0},
    '{16'h771F, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0},
    '{16'h5047, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}
  };

  function automatic logic in_set(input logic [15:0] c);
    in_set = (c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0061 && c <= 16'h007A) ||
             (c == 16'h005F) || (c >= 16'h0030 && c <= 16'h0039) || (c == SPACE) ||
             (c >= 16'h4E00 && c <= 16'h9FFF);
  endfunction

endpackage
`default_nettype wire

// ===== src/idks_match.sv =====
// keyword and boolean word matcher over the head of the token text
`timescale 1ns / 1ps
`default_nettype none
module idks_match #(
  parameter int CNT_BITS = $clog2(idks_pkg::MAX_TEXT_DEF + 1)
) (
  input  wire logic [15:0]         units [idks_pkg::WORD_MAX],
  input  wire logic [CNT_BITS-1:0] len,
  output idks_pkg::match_t         result
);
  import idks_pkg::*;

  always_comb begin
    logic hit_w;
    result = '0;
    for (int w = 0; w < WORD_COUNT; w++) begin
      hit_w = (len == CNT_BITS'(WORD_LEN[w]));
      for (int i = 0; i < WORD_MAX; i++) begin
        if (i < int'(WORD_LEN[w]) && units[i] != WORD_UNIT[w][i]) begin
          hit_w = 1'b0;
        end
      end
      if (hit_w && !result.hit) begin
        result.hit = 1'b1;
        result.is_bool = WORD_BOOL[w];
        result.code = WORD_CODE[w];
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/identifier_keyword_scanner_top.sv =====
// top level of the identifier and keyword scanner
`timescale 1ns / 1ps
`default_nettype none
// Takes one character unit per cycle unless in_stall is high. A unit that causes at most one
// result (a passed unit, or one that only extends an open token) keeps the input running at
// one item per cycle while out_stall is low. A closing token's results leave one per cycle,
// as out_stall allows, through the single output register; the input stalls until the last
// is loaded: one result per keyword or boolean, n per n-unit text token, plus a passed closer.
// Token text is held in a buffer of MAX_TEXT registers; longer text is cut and flagged.
module identifier_keyword_scanner_top #(
  parameter int MAX_TEXT = idks_pkg::MAX_TEXT_DEF,
  parameter int POS_BITS = idks_pkg::POS_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] code_unit,
  input  wire logic        end_of_stream,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [3:0]       keyword_code,
  output logic             bool_value,
  output logic [15:0]      unit_out,
  output logic [31:0]      begin_pos,
  output logic [31:0]      end_pos,
  output logic [5:0]       text_length,
  output logic             truncated,
  output logic             last
);
  import idks_pkg::*;

  localparam int CW = $clog2(MAX_TEXT + 1);
  localparam int IW = $clog2(MAX_TEXT);

  // scanner state
  logic                token_open, token_open_next;
  logic                previous_was_space, previous_was_space_next;
  logic                tail_space, tail_space_next;
  logic [CW-1:0]       text_count, text_count_next;
  logic [POS_BITS-1:0] token_begin, token_begin_next;
  logic [POS_BITS-1:0] stream_position, stream_position_next;
  logic                overflowed, overflowed_next;
  logic [15:0]         text_buf [MAX_TEXT];

  // pending results of the last item
  logic                tok_pending, tok_pending_next;
  logic                pass_pending, pass_pending_next;
  logic [CW-1:0]       tok_n, tok_n_next;
  logic [POS_BITS-1:0] tok_begin, tok_begin_next;
  logic [POS_BITS-1:0] tok_end, tok_end_next;
  logic                tok_ovf, tok_ovf_next;
  logic [IW-1:0]       idx, idx_next;
  logic [15:0]         pass_unit, pass_unit_next;
  logic [POS_BITS-1:0] pass_pos, pass_pos_next;
  logic [POS_BITS-1:0] pass_end, pass_end_next;

  logic                out_valid_next;
  logic                load;
  kind_t               o_kind;
  logic [3:0]          o_code;
  logic                o_bool;
  logic [15:0]         o_unit;
  logic [31:0]         o_begin, o_end;
  logic [5:0]          o_len;
  logic                o_trunc, o_last;

  logic                wr_en;
  logic [IW-1:0]       wr_idx;
  logic                in_accept, busy, slot_free, tok_last, finishing;
  logic [15:0]         head [WORD_MAX];
  match_t              m;
  logic                word_hit;

  always_comb begin
    for (int i = 0; i < WORD_MAX; i++) begin
      head[i] = text_buf[i];
    end
  end

  idks_match #(.CNT_BITS(CW)) u_match (
    .units  (head),
    .len    (tok_n),
    .result (m)
  );

  // truncated text never matches a word
  assign word_hit  = m.hit && !tok_ovf;
  assign busy      = tok_pending || pass_pending;
  assign slot_free = !out_valid || !out_stall;
  assign tok_last  = word_hit || (idx == IW'(tok_n - CW'(1)));
  assign finishing = slot_free && (tok_pending ? (tok_last && !pass_pending) : pass_pending);
  assign in_stall  = busy && !finishing;
  assign in_accept = in_valid && !in_stall;
  assign load      = busy && slot_free;

  always_comb begin
    logic                member, sp, close1;
    logic [POS_BITS-1:0] pos_next;

    token_open_next         = token_open;
    previous_was_space_next = previous_was_space;
    tail_space_next         = tail_space;
    text_count_next         = text_count;
    token_begin_next        = token_begin;
    stream_position_next    = stream_position;
    overflowed_next         = overflowed;
    tok_pending_next        = tok_pending;
    pass_pending_next       = pass_pending;
    tok_n_next              = tok_n;
    tok_begin_next          = tok_begin;
    tok_end_next            = tok_end;
    tok_ovf_next            = tok_ovf;
    idx_next                = idx;
    pass_unit_next          = pass_unit;
    pass_pos_next           = pass_pos;
    pass_end_next           = pass_end;
    out_valid_next          = out_valid && out_stall;
    wr_en                   = 1'b0;
    wr_idx                  = '0;
    o_kind                  = KIND_PASS;
    o_code                  = '0;
    o_bool                  = 1'b0;
    o_unit                  = '0;
    o_begin                 = '0;
    o_end                   = '0;
    o_len                   = '0;
    o_trunc                 = 1'b0;
    o_last                  = 1'b0;
    member                  = in_set(code_unit);
    sp                      = (code_unit == SPACE);
    close1                  = token_open && !member;
    pos_next                = stream_position + POS_BITS'(1);

    // drain one pending result into the output register
    if (load) begin
      out_valid_next = 1'b1;
      if (tok_pending) begin
        o_begin = 32'(tok_begin);
        o_end   = 32'(tok_end);
        o_len   = 6'(tok_n);
        o_last  = tok_last && !pass_pending;
        if (word_hit) begin
          o_kind = m.is_bool ? KIND_BOOL : KIND_KEYWORD;
          o_code = m.is_bool ? 4'd0 : m.code;
          o_bool = m.is_bool && m.code[0];
        end else begin
          o_kind  = KIND_TEXT;
          o_unit  = text_buf[idx];
          o_trunc = tok_ovf;
          idx_next = idx + IW'(1);
        end
        if (tok_last) begin
          tok_pending_next = 1'b0;
        end
      end else begin
        o_kind  = KIND_PASS;
        o_unit  = pass_unit;
        o_begin = 32'(pass_pos);
        o_end   = 32'(pass_end);
        o_last  = 1'b1;
        pass_pending_next = 1'b0;
      end
    end

    // take a new item
    if (in_accept) begin
      tok_pending_next  = 1'b0;
      pass_pending_next = 1'b0;
      idx_next          = '0;
      if (close1) begin
        tok_pending_next        = 1'b1;
        tok_n_next              = text_count - CW'(tail_space);
        tok_begin_next          = token_begin;
        tok_end_next            = stream_position;
        tok_ovf_next            = overflowed;
        token_open_next         = 1'b0;
        previous_was_space_next = 1'b1;
        text_count_next         = '0;
        overflowed_next         = 1'b0;
      end
      if (!token_open_next && member && !sp) begin
        token_open_next         = 1'b1;
        token_begin_next        = stream_position;
        text_count_next         = '0;
        overflowed_next         = 1'b0;
        previous_was_space_next = 1'b1;
        tail_space_next         = 1'b0;
      end
      if (token_open_next) begin
        if (!(sp && previous_was_space_next)) begin
          if (text_count_next < CW'(MAX_TEXT)) begin
            wr_en           = 1'b1;
            wr_idx          = text_count_next[IW-1:0];
            text_count_next = text_count_next + CW'(1);
            tail_space_next = sp;
          end else begin
            overflowed_next = 1'b1;
          end
          previous_was_space_next = sp;
        end
        if (end_of_stream) begin
          tok_pending_next        = 1'b1;
          tok_n_next              = text_count_next - CW'(tail_space_next);
          tok_begin_next          = token_begin_next;
          tok_end_next            = pos_next;
          tok_ovf_next            = overflowed_next;
          token_open_next         = 1'b0;
          previous_was_space_next = 1'b1;
          text_count_next         = '0;
          overflowed_next         = 1'b0;
        end
      end else begin
        pass_pending_next = 1'b1;
        pass_unit_next    = code_unit;
        pass_pos_next     = stream_position;
        pass_end_next     = pos_next;
      end
      stream_position_next = end_of_stream ? '0 : pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_open         <= 1'b0;
      previous_was_space <= 1'b1;
      tail_space         <= 1'b0;
      text_count         <= '0;
      token_begin        <= '0;
      stream_position    <= '0;
      overflowed         <= 1'b0;
      tok_pending        <= 1'b0;
      pass_pending       <= 1'b0;
      idx                <= '0;
      out_valid          <= 1'b0;
    end else begin
      token_open         <= token_open_next;
      previous_was_space <= previous_was_space_next;
      tail_space         <= tail_space_next;
      text_count         <= text_count_next;
      token_begin        <= token_begin_next;
      stream_position    <= stream_position_next;
      overflowed         <= overflowed_next;
      tok_pending        <= tok_pending_next;
      pass_pending       <= pass_pending_next;
      idx                <= idx_next;
      out_valid          <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    tok_n     <= tok_n_next;
    tok_begin <= tok_begin_next;
    tok_end   <= tok_end_next;
    tok_ovf   <= tok_ovf_next;
    pass_unit <= pass_unit_next;
    pass_pos  <= pass_pos_next;
    pass_end  <= pass_end_next;
    if (wr_en) begin
      text_buf[wr_idx] <= code_unit;
    end
    if (load) begin
      kind         <= o_kind;
      keyword_code <= o_code;
      bool_value   <= o_bool;
      unit_out     <= o_unit;
      begin_pos    <= o_begin;
      end_pos      <= o_end;
      text_length  <= o_len;
      truncated    <= o_trunc;
      last         <= o_last;
    end
  end

`ifndef ASSERT_OFF
  a_no_stall_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !in_stall) else $error("input stalled with nothing pending");
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid)
    else $error("result run broken before its last item");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    text_count <= CW'(MAX_TEXT)) else $error("text count past buffer size");
  a_token_nonempty: assert property (@(posedge clk) disable iff (rst)
    tok_pending |-> tok_n != '0) else $error("closed token with empty text");
`endif

endmodule
`default_nettype wire
